>>> sv/kct_pkg.sv
`default_nettype none

package kct_pkg;

   // Strip geometry: one 4-bit label nibble per row
   localparam int ROWS        = 16;
   localparam int ROW_IDX_W   = $clog2(ROWS);
   localparam int NIB_W       = 4;
   localparam int LABEL_W     = ROWS * NIB_W;
   localparam int IDS         = 1 << NIB_W;
   localparam int HEIGHT_W    = 5;
   localparam int COUNT_W     = 5;
   localparam int COMP_W      = 4;
   localparam int CLOSE_STEPS = $clog2(ROWS);

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(16);

   typedef logic [ROWS-1:0]    row_vec_type;
   typedef row_vec_type [ROWS-1:0] row_mat_type;
   typedef logic [IDS-1:0]     id_vec_type;
   typedef logic [LABEL_W-1:0] label_vec_type;

   typedef struct packed {
      label_vec_type old_labels;
      logic          old_touched_top;
      logic          old_touched_bottom;
      row_vec_type   new_mask;
   } request_type;

   typedef struct packed {
      logic               alive;
      label_vec_type      new_labels;
      logic               new_touched_top;
      logic               new_touched_bottom;
      logic [COUNT_W-1:0] new_cell_count;
      logic [COMP_W-1:0]  new_component_count;
   } result_type;

   // One-hot of a component id; the empty label sets nothing
   function automatic id_vec_type id_decode(input logic [NIB_W-1:0] nib);
      id_vec_type d;
      d    = id_vec_type'(1) << nib;
      d[0] = 1'b0;
      return d;
   endfunction

   // Number of set rows
   function automatic logic [COUNT_W-1:0] count_rows(input row_vec_type v);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < ROWS; i++) begin
         n = n + COUNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> sv/kct_conn.sv
`default_nettype none

module kct_conn (
   input  kct_pkg::label_vec_type labels,
   input  kct_pkg::row_vec_type   mask,
   output kct_pkg::row_mat_type   reach,
   output logic                   alive
);

   kct_pkg::id_vec_type  row_id  [kct_pkg::ROWS];
   kct_pkg::id_vec_type  near_id [kct_pkg::ROWS];
   kct_pkg::id_vec_type  present;
   kct_pkg::id_vec_type  touched;
   kct_pkg::id_vec_type  needed;
   kct_pkg::row_mat_type clos    [kct_pkg::CLOSE_STEPS+1];

   // Decode old ids per row and gather the ids seen by each new cell
   always_comb begin
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         row_id[r] = kct_pkg::id_decode(labels[kct_pkg::NIB_W*r +: kct_pkg::NIB_W]);
      end
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         near_id[r] = row_id[r];
         if (r > 0) begin
            near_id[r] = near_id[r] | row_id[r-1];
         end
         if (r < kct_pkg::ROWS - 1) begin
            near_id[r] = near_id[r] | row_id[r+1];
         end
      end
   end

   // Old components present, touched by a new cell, and needed (id up to the highest)
   always_comb begin
      present = '0;
      touched = '0;
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         present = present | row_id[r];
         if (mask[r]) begin
            touched = touched | near_id[r];
         end
      end
      needed[kct_pkg::IDS-1] = present[kct_pkg::IDS-1];
      for (int l = kct_pkg::IDS - 2; l >= 0; l--) begin
         needed[l] = needed[l+1] | present[l];
      end
      alive = &(touched[kct_pkg::IDS-1:1] | ~needed[kct_pkg::IDS-1:1]);
   end

   // Direct links between new cells: vertical neighbours or a shared old id
   always_comb begin
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         for (int s = 0; s < kct_pkg::ROWS; s++) begin
            clos[0][r][s] = mask[r] & mask[s] &
                            ((r == s) || (r + 1 == s) || (s + 1 == r) ||
                             (|(near_id[r] & near_id[s])));
         end
      end
      // Square the symmetric link matrix until every path is covered
      for (int k = 0; k < kct_pkg::CLOSE_STEPS; k++) begin
         for (int r = 0; r < kct_pkg::ROWS; r++) begin
            for (int s = 0; s < kct_pkg::ROWS; s++) begin
               clos[k+1][r][s] = |(clos[k][r] & clos[k][s]);
            end
         end
      end
   end

   assign reach = clos[kct_pkg::CLOSE_STEPS];

endmodule

`default_nettype wire

>>> sv/kct_label.sv
`default_nettype none

module kct_label (
   input  kct_pkg::row_vec_type        mask,
   input  kct_pkg::row_mat_type        reach,
   output kct_pkg::label_vec_type      labels,
   output logic [kct_pkg::COMP_W-1:0]  comp_count
);

   kct_pkg::row_vec_type         first;
   kct_pkg::row_vec_type         rep    [kct_pkg::ROWS];
   logic [kct_pkg::COUNT_W-1:0]  prefix [kct_pkg::ROWS];
   logic [kct_pkg::COUNT_W-1:0]  total;

   // Mark the topmost row of each component and number them in row order
   always_comb begin
      for (int s = 0; s < kct_pkg::ROWS; s++) begin
         first[s] = mask[s] &
                    ~|(reach[s] & ({kct_pkg::ROWS{1'b1}} >> (kct_pkg::ROWS - s)));
      end
      for (int s = 0; s < kct_pkg::ROWS; s++) begin
         prefix[s] = kct_pkg::count_rows(first &
                        ({kct_pkg::ROWS{1'b1}} >> (kct_pkg::ROWS - 1 - s)));
      end
      total      = kct_pkg::count_rows(first);
      comp_count = total[kct_pkg::COMP_W-1:0];
   end

   // Give each new cell the number of its component's topmost row
   always_comb begin
      labels = '0;
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         rep[r] = reach[r] & kct_pkg::row_vec_type'(~reach[r] + 1'b1);
         for (int s = 0; s < kct_pkg::ROWS; s++) begin
            if (rep[r][s]) begin
               labels[kct_pkg::NIB_W*r +: kct_pkg::NIB_W] =
                  labels[kct_pkg::NIB_W*r +: kct_pkg::NIB_W] |
                  prefix[s][kct_pkg::NIB_W-1:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/king_column_transfer_step_top.sv
// Channel | Handshake               | Payload
// --------+-------------------------+----------------------------------------------
// req     | req_valid / req_ready   | old_labels, old_touched_top/bottom, new_mask
// rsp     | rsp_valid / rsp_ready   | alive, new_labels, new_touched_top/bottom,
//         |                         | new_cell_count, new_component_count
// csr     | csr_valid / csr_ready   | height (ready whenever reset is low)
//
// One request per cycle while the result slot is free or being emptied; its result passes
// through the request register, then the result register, to the rsp ports.
// The cycle is set by the connectivity closure: four squarings of a 16x16 link matrix.
// Synchronous reset clears both valid flags, sets height to 16 and holds both readies low.
// A stalled result holds the result register; the request register keeps its
// request and req_ready drops only when both registers are full.
`default_nettype none

module king_column_transfer_step_top #(
   parameter int MAX_HEIGHT = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [kct_pkg::HEIGHT_W-1:0] csr_height,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [kct_pkg::LABEL_W-1:0]  req_old_labels,
   input  wire logic                         req_old_touched_top,
   input  wire logic                         req_old_touched_bottom,
   input  wire logic [kct_pkg::ROWS-1:0]     req_new_mask,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_alive,
   output logic [kct_pkg::LABEL_W-1:0]       rsp_new_labels,
   output logic                              rsp_new_touched_top,
   output logic                              rsp_new_touched_bottom,
   output logic [kct_pkg::COUNT_W-1:0]       rsp_new_cell_count,
   output logic [kct_pkg::COMP_W-1:0]        rsp_new_component_count
);

   localparam int ROW_LIMIT = (MAX_HEIGHT < kct_pkg::ROWS) ? MAX_HEIGHT : kct_pkg::ROWS;
   localparam logic [kct_pkg::HEIGHT_W-1:0] LIMIT_CODE = kct_pkg::HEIGHT_W'(ROW_LIMIT);

   logic [kct_pkg::HEIGHT_W-1:0]  height_ff, height_in;
   logic [kct_pkg::HEIGHT_W-1:0]  eff_height;
   logic [kct_pkg::ROW_IDX_W-1:0] last_row;
   logic                          in_valid_ff, in_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   kct_pkg::request_type          in_req_ff, in_req_in;
   kct_pkg::result_type           rsp_ff, rsp_in;
   logic                          slot_free;
   kct_pkg::row_vec_type          use_rows;
   kct_pkg::row_vec_type          mask_use;
   kct_pkg::label_vec_type        labels_use;
   kct_pkg::row_mat_type          reach;
   logic                          alive;
   kct_pkg::label_vec_type        new_labels;
   logic [kct_pkg::COMP_W-1:0]    comp_count;

   // Height register
   assign csr_ready = !reset;
   assign height_in = csr_valid ? csr_height : height_ff;

   always_comb begin
      priority if (height_ff == '0) begin
         eff_height = kct_pkg::HEIGHT_W'(1);
      end else if (height_ff > LIMIT_CODE) begin
         eff_height = LIMIT_CODE;
      end else begin
         eff_height = height_ff;
      end
   end

   assign last_row = kct_pkg::ROW_IDX_W'(eff_height - kct_pkg::HEIGHT_W'(1));

   // Handshake: advance when the result slot is free or being emptied
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !reset && (!in_valid_ff || slot_free);
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = slot_free ? in_valid_ff : rsp_valid_ff;

   always_comb begin
      in_req_in = in_req_ff;
      if (req_valid && req_ready) begin
         in_req_in.old_labels         = req_old_labels;
         in_req_in.old_touched_top    = req_old_touched_top;
         in_req_in.old_touched_bottom = req_old_touched_bottom;
         in_req_in.new_mask           = req_new_mask;
      end
   end

   // Drop rows beyond the height in use
   always_comb begin
      for (int r = 0; r < kct_pkg::ROWS; r++) begin
         use_rows[r] = (kct_pkg::HEIGHT_W'(r) < eff_height);
         labels_use[kct_pkg::NIB_W*r +: kct_pkg::NIB_W] =
            use_rows[r] ? in_req_ff.old_labels[kct_pkg::NIB_W*r +: kct_pkg::NIB_W] : '0;
      end
      mask_use = in_req_ff.new_mask & use_rows;
   end

   kct_conn u_conn (
      .labels (labels_use),
      .mask   (mask_use),
      .reach  (reach),
      .alive  (alive)
   );

   kct_label u_label (
      .mask       (mask_use),
      .reach      (reach),
      .labels     (new_labels),
      .comp_count (comp_count)
   );

   // Assemble the result; a dead request yields all zeros
   always_comb begin
      rsp_in = rsp_ff;
      if (slot_free) begin
         rsp_in = '0;
         if (alive) begin
            rsp_in.alive               = 1'b1;
            rsp_in.new_labels          = new_labels;
            rsp_in.new_touched_top     = in_req_ff.old_touched_top | mask_use[0];
            rsp_in.new_touched_bottom  = in_req_ff.old_touched_bottom | mask_use[last_row];
            rsp_in.new_cell_count      = kct_pkg::count_rows(mask_use);
            rsp_in.new_component_count = comp_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= kct_pkg::HEIGHT_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         height_ff    <= height_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_alive               = rsp_ff.alive;
   assign rsp_new_labels          = rsp_ff.new_labels;
   assign rsp_new_touched_top     = rsp_ff.new_touched_top;
   assign rsp_new_touched_bottom  = rsp_ff.new_touched_bottom;
   assign rsp_new_cell_count      = rsp_ff.new_cell_count;
   assign rsp_new_component_count = rsp_ff.new_component_count;

   // A dead result carries nothing else
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alive |-> rsp_new_labels == '0 && rsp_new_cell_count == '0 &&
         rsp_new_component_count == '0 && !rsp_new_touched_top && !rsp_new_touched_bottom)
      else $error("dead result with non-zero fields");

   // Components never outnumber cells
   a_comp_cells: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alive |->
         kct_pkg::COUNT_W'(rsp_new_component_count) <= rsp_new_cell_count)
      else $error("component count above cell count");

   // A registered request moves to the result register when the slot is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && slot_free |=> rsp_valid)
      else $error("request lost on its way to the result register");

   // A blocked request stays in the request register
   a_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !slot_free |=> in_valid_ff && $stable(in_req_ff))
      else $error("blocked request dropped or changed");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_ROWS = 16;

   // Expected column results, oldest first, worked out from each accepted request
   class kct_scoreboard;
      kct_pkg::result_type          expected_q[$];
      logic [kct_pkg::HEIGHT_W-1:0] height_reg;
      int                           errors;
      int unsigned                  link[32];

      function new();
         height_reg = kct_pkg::HEIGHT_RESET;
         errors     = 0;
      endfunction

      // Clamp the programmed height to the rows that exist
      function int unsigned rows_in_use();
         int unsigned rows;
         rows = 32'(height_reg);
         if (rows < 1) rows = 1;
         if (rows > LIMIT_ROWS) rows = LIMIT_ROWS;
         return rows;
      endfunction

      function int unsigned root(int unsigned n);
         while (link[n] != n) n = link[n];
         return n;
      endfunction

      function void join_nodes(int unsigned a, int unsigned b);
         int unsigned ra, rb;
         ra = root(a);
         rb = root(b);
         if (ra != rb) link[ra] = rb;
      endfunction

      // Nodes 0..15 are new cells by row, 16+id is old component id
      function kct_pkg::result_type column_step(kct_pkg::request_type rq);
         kct_pkg::result_type  rs;
         int unsigned          rows, top_id, cells, next_label, rt, lo, hi;
         logic [3:0]           lab[16];
         kct_pkg::row_vec_type mask;
         bit [31:0]            has_cell;
         int unsigned          relabel[32];
         rs   = '0;
         rows = rows_in_use();
         top_id = 0;
         mask = rq.new_mask;
         for (int unsigned r = 0; r < 16; r++) begin
            lab[r] = (r < rows) ? rq.old_labels[4*r +: 4] : 4'd0;
            if (lab[r] > top_id) top_id = 32'(lab[r]);
            if (r >= rows) mask[r] = 1'b0;
         end
         for (int unsigned n = 0; n < 32; n++) link[n] = n;

         // Join vertical neighbours and king-adjacent old cells
         cells = 0;
         for (int unsigned r = 0; r < rows; r++) begin
            if (mask[r]) begin
               cells++;
               if (r + 1 < rows && mask[r+1]) join_nodes(r, r + 1);
               lo = (r == 0) ? 0 : r - 1;
               hi = (r + 1 < rows) ? r + 1 : r;
               for (int unsigned rr = lo; rr <= hi; rr++) begin
                  if (lab[rr] != 0) join_nodes(r, 16 + 32'(lab[rr]));
               end
            end
         end

         // Drop the column if any old id reaches no new cell
         has_cell = '0;
         for (int unsigned r = 0; r < rows; r++) begin
            if (mask[r]) has_cell[root(r)] = 1'b1;
         end
         for (int unsigned id = 1; id <= top_id; id++) begin
            if (!has_cell[root(16 + id)]) return rs;
         end

         // Relabel in order of first appearance from row 0 upwards
         for (int unsigned n = 0; n < 32; n++) relabel[n] = 0;
         next_label = 1;
         for (int unsigned r = 0; r < rows; r++) begin
            if (mask[r]) begin
               rt = root(r);
               if (relabel[rt] == 0) begin
                  relabel[rt] = next_label;
                  next_label++;
               end
               rs.new_labels[4*r +: 4] = relabel[rt][3:0];
            end
         end
         rs.alive               = 1'b1;
         rs.new_touched_top     = rq.old_touched_top | mask[0];
         rs.new_touched_bottom  = rq.old_touched_bottom | mask[rows-1];
         rs.new_cell_count      = kct_pkg::COUNT_W'(cells);
         rs.new_component_count = kct_pkg::COMP_W'(next_label - 1);
         return rs;
      endfunction

      function void note_request(kct_pkg::request_type rq);
         expected_q.push_back(column_step(rq));
      endfunction

      function void check_result(kct_pkg::result_type got);
         kct_pkg::result_type exp_rs;
         if (expected_q.size() == 0) begin
            $error("unexpected result: new_labels %h", got.new_labels);
            errors++;
            return;
         end
         exp_rs = expected_q.pop_front();
         if (got.alive !== exp_rs.alive) begin
            $error("alive: expected %0d, actual %0d", exp_rs.alive, got.alive);
            errors++;
         end
         if (got.new_labels !== exp_rs.new_labels) begin
            $error("new_labels: expected %h, actual %h", exp_rs.new_labels, got.new_labels);
            errors++;
         end
         if (got.new_touched_top !== exp_rs.new_touched_top) begin
            $error("new_touched_top: expected %0d, actual %0d",
                   exp_rs.new_touched_top, got.new_touched_top);
            errors++;
         end
         if (got.new_touched_bottom !== exp_rs.new_touched_bottom) begin
            $error("new_touched_bottom: expected %0d, actual %0d",
                   exp_rs.new_touched_bottom, got.new_touched_bottom);
            errors++;
         end
         if (got.new_cell_count !== exp_rs.new_cell_count) begin
            $error("new_cell_count: expected %0d, actual %0d",
                   exp_rs.new_cell_count, got.new_cell_count);
            errors++;
         end
         if (got.new_component_count !== exp_rs.new_component_count) begin
            $error("new_component_count: expected %0d, actual %0d",
                   exp_rs.new_component_count, got.new_component_count);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset                  = 1'b1;
   logic                         csr_valid              = 1'b0;
   logic                         csr_ready;
   logic [kct_pkg::HEIGHT_W-1:0] csr_height             = kct_pkg::HEIGHT_RESET;
   logic                         req_valid              = 1'b0;
   logic                         req_ready;
   kct_pkg::label_vec_type       req_old_labels         = '0;
   logic                         req_old_touched_top    = 1'b0;
   logic                         req_old_touched_bottom = 1'b0;
   kct_pkg::row_vec_type         req_new_mask           = '0;
   logic                         rsp_valid;
   logic                         rsp_ready              = 1'b0;
   logic                         rsp_alive;
   kct_pkg::label_vec_type       rsp_new_labels;
   logic                         rsp_new_touched_top;
   logic                         rsp_new_touched_bottom;
   logic [kct_pkg::COUNT_W-1:0]  rsp_new_cell_count;
   logic [kct_pkg::COMP_W-1:0]   rsp_new_component_count;
   kct_pkg::result_type          rsp_seen;

   kct_scoreboard                sb;
   bit                           calm = 1'b0;
   int                           results_taken = 0;
   int                           hold_left = 0;
   bit                           hold_done = 1'b0;
   logic [kct_pkg::HEIGHT_W-1:0] phase_heights[8] = '{5'd1, 5'd0, 5'd31, 5'd7,
                                                      5'd16, 5'd3, 5'd12, 5'd20};

   king_column_transfer_step_top #(
      .MAX_HEIGHT (LIMIT_ROWS)
   ) u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_height              (csr_height),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_old_labels          (req_old_labels),
      .req_old_touched_top     (req_old_touched_top),
      .req_old_touched_bottom  (req_old_touched_bottom),
      .req_new_mask            (req_new_mask),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_alive               (rsp_alive),
      .rsp_new_labels          (rsp_new_labels),
      .rsp_new_touched_top     (rsp_new_touched_top),
      .rsp_new_touched_bottom  (rsp_new_touched_bottom),
      .rsp_new_cell_count      (rsp_new_cell_count),
      .rsp_new_component_count (rsp_new_component_count)
   );

   assign rsp_seen = {rsp_alive, rsp_new_labels, rsp_new_touched_top,
                      rsp_new_touched_bottom, rsp_new_cell_count, rsp_new_component_count};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check each taken result; stall at random, and once hold off for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_seen);
            results_taken++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_taken >= 300) begin
            hold_done = 1'b1;
            hold_left = 80;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 32);
         end
      end
   end

   // Offer one request, idling first at random; returns on the accepting edge
   task automatic offer_request(input kct_pkg::label_vec_type labels, input logic top,
                                input logic bottom, input kct_pkg::row_vec_type mask);
      kct_pkg::request_type rq;
      rq = '{old_labels: labels, old_touched_top: top,
             old_touched_bottom: bottom, new_mask: mask};
      if (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 32);
      end
      req_valid              <= 1'b1;
      req_old_labels         <= labels;
      req_old_touched_top    <= top;
      req_old_touched_bottom <= bottom;
      req_new_mask           <= mask;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rq);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_height(input logic [kct_pkg::HEIGHT_W-1:0] value);
      csr_valid  <= 1'b1;
      csr_height <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.height_reg = value;
   endtask

   // Mostly columns whose old ids all reach a new cell, the rest pure noise
   function automatic kct_pkg::request_type random_column(input int unsigned rows);
      kct_pkg::request_type rq;
      int unsigned          top_id, pick, lo, hi;
      logic [3:0]           nib;
      bit                   covered;
      rq.old_labels         = {$urandom, $urandom};
      rq.old_touched_top    = 1'($urandom_range(1));
      rq.old_touched_bottom = 1'($urandom_range(1));
      case ($urandom_range(2))
         0: rq.new_mask = kct_pkg::row_vec_type'($urandom);
         1: rq.new_mask = kct_pkg::row_vec_type'($urandom & $urandom);
         default: rq.new_mask = kct_pkg::row_vec_type'($urandom & $urandom & $urandom);
      endcase
      if ($urandom_range(99) < 20) return rq;

      // Grow old labels in restricted-growth form, ids up to 8
      top_id = 0;
      for (int unsigned r = 0; r < rows; r++) begin
         if ($urandom_range(99) < 45) begin
            nib = 4'd0;
         end else begin
            nib = 4'($urandom_range((top_id < 8) ? top_id + 1 : 8, 1));
            if (nib > top_id) top_id = 32'(nib);
         end
         rq.old_labels[4*r +: 4] = nib;
      end

      // Give each old id a neighbouring new cell, leaving a few stranded
      for (int unsigned id = 1; id <= top_id; id++) begin
         covered = 1'b0;
         pick    = 0;
         for (int unsigned r = 0; r < rows; r++) begin
            if (rq.old_labels[4*r +: 4] == id) begin
               pick = r;
               lo = (r == 0) ? 0 : r - 1;
               hi = (r + 1 < rows) ? r + 1 : r;
               for (int unsigned rr = lo; rr <= hi; rr++) begin
                  if (rq.new_mask[rr]) covered = 1'b1;
               end
            end
         end
         if (!covered && $urandom_range(99) >= 5) begin
            lo = (pick == 0) ? 0 : pick - 1;
            hi = (pick + 1 < rows) ? pick + 1 : pick;
            rq.new_mask[$urandom_range(hi, lo)] = 1'b1;
         end
      end
      return rq;
   endfunction

   initial begin
      kct_pkg::request_type rq;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed columns at the reset height
      offer_request('0, 1'b0, 1'b0, 16'h0000);
      offer_request('0, 1'b0, 1'b0, 16'hFFFF);
      offer_request({16{4'hF}}, 1'b1, 1'b1, 16'hFFFF);
      offer_request({16{4'h1}}, 1'b0, 1'b1, 16'hFFFF);
      offer_request(64'h1, 1'b0, 1'b0, 16'h0000);
      offer_request('0, 1'b1, 1'b1, 16'h0000);
      offer_request('0, 1'b0, 1'b0, 16'h5555);
      offer_request('0, 1'b0, 1'b0, 16'hAAAA);
      offer_request('0, 1'b0, 1'b0, 16'h8001);
      offer_request('0, 1'b1, 1'b0, 16'h4000);
      offer_request(64'h100, 1'b0, 1'b0, 16'h000A);
      offer_request(64'h201, 1'b0, 1'b0, 16'h0002);
      offer_request(64'h1_0000_0001, 1'b0, 1'b0, 16'h0101);
      offer_request(64'h1, 1'b0, 1'b0, 16'h0004);
      offer_request(64'h30_0001, 1'b0, 1'b0, 16'hFFFF);
      offer_request(64'h2, 1'b0, 1'b0, 16'h0001);
      offer_request(64'h9, 1'b1, 1'b0, 16'h0002);
      offer_request(64'hF000_0000_0000_0000, 1'b0, 1'b1, 16'h8000);
      offer_request(64'h2100_0000_0000_0012, 1'b0, 1'b0, 16'hC003);
      offer_request(64'h8765_4321_0000_0000, 1'b1, 1'b1, 16'hFF00);

      // Random phases over a spread of heights, one of them without idling
      foreach (phase_heights[p]) begin
         settle_pipeline();
         write_height(phase_heights[p]);
         calm = (p == 4);
         repeat (175) begin
            rq = random_column(sb.rows_in_use());
            offer_request(rq.old_labels, rq.old_touched_top,
                          rq.old_touched_bottom, rq.new_mask);
         end
      end
      settle_pipeline();
      repeat (8) @(posedge clock);

      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
